// ===== hw/rtl/lsts_pkg.sv =====
// lsts_pkg: shared types and constants for the lua source token scanner
// holds the scan mode enum, the per-item control struct and character codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lsts_pkg;

   // default bound on the '=' run of a long bracket opener
   localparam int MAX_LEVEL_DEFAULT = 15;

   // depth of the recent byte window
   localparam int WIN_DEPTH = 8;

   // search token register codes
   localparam logic TOKEN_GOTO  = 1'b0;
   localparam logic TOKEN_CLOSE = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_DASH      = 8'h2D;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_EQUAL     = 8'h3D;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LT        = 8'h3C;
   localparam logic [7:0] CHAR_GT        = 8'h3E;
   localparam logic [7:0] CHAR_LOWER_C   = 8'h63;
   localparam logic [7:0] CHAR_LOWER_E   = 8'h65;
   localparam logic [7:0] CHAR_LOWER_G   = 8'h67;
   localparam logic [7:0] CHAR_LOWER_L   = 8'h6C;
   localparam logic [7:0] CHAR_LOWER_O   = 8'h6F;
   localparam logic [7:0] CHAR_LOWER_S   = 8'h73;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;

   // lexer modes
   typedef enum logic [3:0] {
      MODE_PLAIN,
      MODE_DASH,
      MODE_DASHES,
      MODE_OPEN,
      MODE_COPEN,
      MODE_QUOTE,
      MODE_ESCAPE,
      MODE_LONG,
      MODE_LINE
   } mode_type;

   // control for one item leaving the input register
   typedef struct packed {
      logic step;   // item advances this cycle
      logic has;    // item carries a byte
      logic last;   // item ends the source
   } step_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lsts_lexer.sv =====
// lsts_lexer: lexer mode register and per-byte mode transitions
// tells whether the current byte is scanned as plain code; tracks level overflow
// depends on lsts_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsts_lexer #(
   parameter int MAX_LEVEL = lsts_pkg::MAX_LEVEL_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lsts_pkg::step_type ctrl,
   input  wire logic [7:0]        char_byte,
   output logic                   plain,
   output logic                   overflow
);

   localparam int LEVEL_W = $clog2(MAX_LEVEL + 1);
   localparam int CLOSE_W = $clog2(MAX_LEVEL + 2);

   lsts_pkg::mode_type  mode_ff, mode_in;
   logic                quote_ff, quote_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [CLOSE_W-1:0]  close_ff, close_in;
   logic                ovf_ff, ovf_in;
   logic                ovf_set;
   logic                restart;
   logic [CLOSE_W-1:0]  level_ext;

   assign level_ext = CLOSE_W'(level_ff);

   // next mode for one byte
   always_comb begin
      mode_in  = mode_ff;
      quote_in = quote_ff;
      level_in = level_ff;
      close_in = close_ff;
      ovf_set  = 1'b0;
      plain    = 1'b0;
      restart  = 1'b0;
      unique case (mode_ff)
         lsts_pkg::MODE_PLAIN: begin
            plain   = 1'b1;
            restart = 1'b1;
         end
         lsts_pkg::MODE_DASH: begin
            if (char_byte == lsts_pkg::CHAR_DASH) begin
               mode_in = lsts_pkg::MODE_DASHES;
            end else begin
               plain   = 1'b1;
               restart = 1'b1;
            end
         end
         lsts_pkg::MODE_DASHES: begin
            if (char_byte == lsts_pkg::CHAR_LBRACKET) begin
               mode_in  = lsts_pkg::MODE_COPEN;
               level_in = '0;
            end else if (char_byte == lsts_pkg::CHAR_NEWLINE) begin
               mode_in = lsts_pkg::MODE_PLAIN;
               plain   = 1'b1;
            end else begin
               mode_in = lsts_pkg::MODE_LINE;
            end
         end
         lsts_pkg::MODE_LINE: begin
            if (char_byte == lsts_pkg::CHAR_NEWLINE) begin
               mode_in = lsts_pkg::MODE_PLAIN;
               plain   = 1'b1;
            end
         end
         lsts_pkg::MODE_OPEN, lsts_pkg::MODE_COPEN: begin
            if (char_byte == lsts_pkg::CHAR_EQUAL) begin
               if (level_ff >= LEVEL_W'(MAX_LEVEL)) begin
                  level_in = LEVEL_W'(MAX_LEVEL);
                  ovf_set  = 1'b1;
               end else begin
                  level_in = level_ff + LEVEL_W'(1);
               end
               plain = (mode_ff == lsts_pkg::MODE_OPEN);
            end else if (char_byte == lsts_pkg::CHAR_LBRACKET) begin
               mode_in  = lsts_pkg::MODE_LONG;
               close_in = '0;
            end else if (mode_ff == lsts_pkg::MODE_OPEN) begin
               plain   = 1'b1;
               restart = 1'b1;
            end else if (char_byte == lsts_pkg::CHAR_NEWLINE) begin
               mode_in = lsts_pkg::MODE_PLAIN;
               plain   = 1'b1;
            end else begin
               mode_in = lsts_pkg::MODE_LINE;
            end
         end
         lsts_pkg::MODE_QUOTE: begin
            if (char_byte == lsts_pkg::CHAR_BACKSLASH) begin
               mode_in = lsts_pkg::MODE_ESCAPE;
            end else if (char_byte == (quote_ff ? lsts_pkg::CHAR_DQUOTE
                                                : lsts_pkg::CHAR_SQUOTE)) begin
               mode_in = lsts_pkg::MODE_PLAIN;
            end
         end
         lsts_pkg::MODE_ESCAPE: begin
            mode_in = lsts_pkg::MODE_QUOTE;
         end
         lsts_pkg::MODE_LONG: begin
            if (char_byte == lsts_pkg::CHAR_RBRACKET) begin
               if (close_ff != '0 && close_ff == level_ext + CLOSE_W'(1)) begin
                  mode_in  = lsts_pkg::MODE_PLAIN;
                  close_in = '0;
               end else begin
                  close_in = CLOSE_W'(1);
               end
            end else if (char_byte == lsts_pkg::CHAR_EQUAL && close_ff != '0) begin
               if (close_ff <= level_ext) begin
                  close_in = close_ff + CLOSE_W'(1);
               end else begin
                  close_in = '0;
               end
            end else begin
               close_in = '0;
            end
         end
         default: begin
            mode_in = lsts_pkg::MODE_PLAIN;
         end
      endcase

      // a byte in plain code may open a string, a comment or a long bracket
      if (restart) begin
         mode_in = lsts_pkg::MODE_PLAIN;
         if (char_byte == lsts_pkg::CHAR_SQUOTE || char_byte == lsts_pkg::CHAR_DQUOTE) begin
            mode_in  = lsts_pkg::MODE_QUOTE;
            quote_in = (char_byte == lsts_pkg::CHAR_DQUOTE);
         end else if (char_byte == lsts_pkg::CHAR_DASH) begin
            mode_in = lsts_pkg::MODE_DASH;
         end else if (char_byte == lsts_pkg::CHAR_LBRACKET) begin
            mode_in  = lsts_pkg::MODE_OPEN;
            level_in = '0;
         end
      end
   end

   // overflow seen so far including this item
   assign ovf_in   = ovf_ff | (ctrl.has & ovf_set);
   assign overflow = ovf_in;

   // mode registers, cleared at end of source
   always_ff @(posedge clock) begin
      if (reset || (ctrl.step && ctrl.last)) begin
         mode_ff  <= lsts_pkg::MODE_PLAIN;
         quote_ff <= 1'b0;
         level_ff <= '0;
         close_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (ctrl.step && ctrl.has) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         level_ff <= level_in;
         close_ff <= close_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lsts_matcher.sv =====
// lsts_matcher: recent byte window and token match against it
// shifts in each byte with its plain tag and keeps the found flag
// depends on lsts_pkg
`timescale 1ns / 1ps
`default_nettype none

module lsts_matcher (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lsts_pkg::step_type ctrl,
   input  wire logic [7:0]         char_byte,
   input  wire logic               plain,
   input  wire logic               search_token,
   output logic                    found
);

   localparam int W = lsts_pkg::WIN_DEPTH;

   logic [7:0] bytes_ff [W];
   logic [7:0] bytes_nx [W];
   logic [W-1:0] valid_ff, valid_nx, valid_in;
   logic [W-1:0] plain_ff, plain_nx;
   logic found_ff, found_in;
   logic goto_hit, close_hit, end_hit;

   function automatic logic ident_byte(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
   endfunction

   // window after this item
   always_comb begin
      if (ctrl.has) begin
         bytes_nx[0] = char_byte;
         for (int i = 1; i < W; i++) begin
            bytes_nx[i] = bytes_ff[i-1];
         end
         valid_nx = {valid_ff[W-2:0], 1'b1};
         plain_nx = {plain_ff[W-2:0], plain};
      end else begin
         for (int i = 0; i < W; i++) begin
            bytes_nx[i] = bytes_ff[i];
         end
         valid_nx = valid_ff;
         plain_nx = plain_ff;
      end
   end

   // goto ending one byte back, followed by a non-identifier byte
   assign goto_hit = ctrl.has && search_token == lsts_pkg::TOKEN_GOTO &&
      valid_nx[4] && plain_nx[4] && (&valid_nx[4:1]) &&
      bytes_nx[4] == lsts_pkg::CHAR_LOWER_G && bytes_nx[3] == lsts_pkg::CHAR_LOWER_O &&
      bytes_nx[2] == lsts_pkg::CHAR_LOWER_T && bytes_nx[1] == lsts_pkg::CHAR_LOWER_O &&
      (!valid_nx[5] || !ident_byte(bytes_nx[5])) && !ident_byte(char_byte);

   // <close> ending at the newest byte
   assign close_hit = ctrl.has && search_token == lsts_pkg::TOKEN_CLOSE &&
      plain_nx[6] && (&valid_nx[6:0]) &&
      bytes_nx[6] == lsts_pkg::CHAR_LT && bytes_nx[5] == lsts_pkg::CHAR_LOWER_C &&
      bytes_nx[4] == lsts_pkg::CHAR_LOWER_L && bytes_nx[3] == lsts_pkg::CHAR_LOWER_O &&
      bytes_nx[2] == lsts_pkg::CHAR_LOWER_S && bytes_nx[1] == lsts_pkg::CHAR_LOWER_E &&
      bytes_nx[0] == lsts_pkg::CHAR_GT;

   // goto at the very end of the source
   assign end_hit = ctrl.last && search_token == lsts_pkg::TOKEN_GOTO &&
      plain_nx[3] && (&valid_nx[3:0]) &&
      bytes_nx[3] == lsts_pkg::CHAR_LOWER_G && bytes_nx[2] == lsts_pkg::CHAR_LOWER_O &&
      bytes_nx[1] == lsts_pkg::CHAR_LOWER_T && bytes_nx[0] == lsts_pkg::CHAR_LOWER_O &&
      (!valid_nx[4] || !ident_byte(bytes_nx[4]));

   assign found_in = found_ff | goto_hit | close_hit | end_hit;
   assign found    = found_in;
   assign valid_in = ctrl.last ? '0 : valid_nx;

   // window control state, cleared at end of source
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         plain_ff <= '0;
         found_ff <= 1'b0;
      end else if (ctrl.step) begin
         valid_ff <= valid_in;
         plain_ff <= ctrl.last ? '0 : plain_nx;
         found_ff <= ctrl.last ? 1'b0 : found_in;
      end
   end

   // window bytes, read only where valid
   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         for (int i = 0; i < W; i++) begin
            bytes_ff[i] <= bytes_nx[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lua_source_token_scanner.sv =====
// lua_source_token_scanner: top level of the lua source token scanner
// Lua source streams in at most one byte per request on req_; at the end
// of the source one result on rsp_ says whether the chosen token was seen in
// plain code, outside strings, comments and long brackets, and whether a long
// bracket level ran past MAX_LEVEL.
// csr_we/csr_wdata select the token: 0 for goto with identifier boundaries,
// 1 for <close>; write it only while the block is idle.
// Throughput: one request per cycle, except while a request that ends the
// source waits for the result register. A request is held in the input
// register and scanned there; its result goes to the result register, one
// mode update plus an eight-byte window compare between the two registers.
// A result waiting on a stalled receiver does not stop byte requests; only
// a request that ends the source waits in the input register until the
// result register is free, which then holds req_tready low.
// Reset (synchronous) returns to plain code with an empty window and cleared
// flags and selects goto; after each result the scan state clears likewise
// while the token selection is kept.
// depends on lsts_pkg, lsts_lexer, lsts_matcher
`timescale 1ns / 1ps
`default_nettype none

module lua_source_token_scanner #(
   parameter int MAX_LEVEL = lsts_pkg::MAX_LEVEL_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration
   input  wire logic       csr_we,
   input  wire logic       csr_wdata,     // search_token
   // request stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,     // [7:0] char_byte
   input  wire logic       req_tuser,     // [0] has_char
   input  wire logic       req_tlast,     // is_last
   // result stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,     // [0] found, [7:1] zero
   output logic            rsp_tuser      // [0] level_overflow
);

   logic       token_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_has_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff;
   logic       found_ff;
   logic       ovf_ff;
   logic       advance;
   logic       plain;
   logic       found;
   logic       overflow;
   lsts_pkg::step_type ctrl;

   // token selection register
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= lsts_pkg::TOKEN_GOTO;
      end else if (csr_we) begin
         token_ff <= csr_wdata;
      end
   end

   // an ending request needs a free result register
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_has_ff  <= req_tuser;
         in_last_ff <= req_tlast;
      end
   end

   assign ctrl.step = advance;
   assign ctrl.has  = in_valid_ff & in_has_ff;
   assign ctrl.last = in_valid_ff & in_last_ff;

   lsts_lexer #(
      .MAX_LEVEL(MAX_LEVEL)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .char_byte (in_byte_ff),
      .plain     (plain),
      .overflow  (overflow)
   );

   lsts_matcher u_matcher (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .char_byte    (in_byte_ff),
      .plain        (plain),
      .search_token (token_ff),
      .found        (found)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         found_ff <= found;
         ovf_ff   <= overflow;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, found_ff};
   assign rsp_tuser  = ovf_ff;

endmodule

`default_nettype wire

// ===== bench/lua_source_token_scanner_tb.sv =====
// lua_source_token_scanner_tb: self-checking bench for the lua source token scanner
// drives source text as byte requests, predicts each end-of-source verdict and checks it
// depends on lsts_pkg and lua_source_token_scanner
`timescale 1ns / 1ps

module lua_source_token_scanner_tb;

   localparam int MAX_LEVEL = lsts_pkg::MAX_LEVEL_DEFAULT;

   // expected verdict for one source
   typedef struct packed {
      logic found;
      logic level_overflow;
   } verdict_type;

   typedef enum int {STALL_NONE, STALL_FULL, STALL_RANDOM} stall_mode_type;

   // lexer predictor plus the queue of verdicts still owed by the block
   class token_verdict_board;
      lsts_pkg::mode_type mode;
      logic        dq_string;
      logic [4:0]  open_level;
      logic [4:0]  close_count;
      logic [7:0]  win_byte [lsts_pkg::WIN_DEPTH];
      logic        win_valid [lsts_pkg::WIN_DEPTH];
      logic        win_plain [lsts_pkg::WIN_DEPTH];
      logic        seen_flag;
      logic        level_over;
      logic        token_close;
      verdict_type expected_verdicts [$];
      int          errors;
      int          checked;
      int          found_count;
      int          overflow_count;

      function new();
         token_close = lsts_pkg::TOKEN_GOTO;
         errors = 0;
         checked = 0;
         found_count = 0;
         overflow_count = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         mode = lsts_pkg::MODE_PLAIN;
         dq_string = 1'b0;
         open_level = '0;
         close_count = '0;
         seen_flag = 1'b0;
         level_over = 1'b0;
         for (int i = 0; i < lsts_pkg::WIN_DEPTH; i++) begin
            win_byte[i] = '0;
            win_valid[i] = 1'b0;
            win_plain[i] = 1'b0;
         end
      endfunction

      function void select_token(logic value);
         token_close = value;
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      function bit ident_char(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                (c >= "0" && c <= "9") || c == "_";
      endfunction

      // byte in plain code may open a string, a comment or a long bracket
      function void plain_char(logic [7:0] c);
         if (c == lsts_pkg::CHAR_SQUOTE || c == lsts_pkg::CHAR_DQUOTE) begin
            mode = lsts_pkg::MODE_QUOTE;
            dq_string = (c == lsts_pkg::CHAR_DQUOTE);
         end else if (c == lsts_pkg::CHAR_DASH) begin
            mode = lsts_pkg::MODE_DASH;
         end else if (c == lsts_pkg::CHAR_LBRACKET) begin
            mode = lsts_pkg::MODE_OPEN;
            open_level = '0;
         end
      endfunction

      // advance the lexer, return 1 when the byte counts as plain code
      function bit scan_char(logic [7:0] c);
         case (mode)
            lsts_pkg::MODE_PLAIN: begin
               plain_char(c);
               return 1'b1;
            end
            lsts_pkg::MODE_DASH: begin
               if (c == lsts_pkg::CHAR_DASH) begin
                  mode = lsts_pkg::MODE_DASHES;
                  return 1'b0;
               end
               mode = lsts_pkg::MODE_PLAIN;
               plain_char(c);
               return 1'b1;
            end
            lsts_pkg::MODE_DASHES: begin
               if (c == lsts_pkg::CHAR_LBRACKET) begin
                  mode = lsts_pkg::MODE_COPEN;
                  open_level = '0;
               end else if (c == lsts_pkg::CHAR_NEWLINE) begin
                  mode = lsts_pkg::MODE_PLAIN;
                  return 1'b1;
               end else begin
                  mode = lsts_pkg::MODE_LINE;
               end
               return 1'b0;
            end
            lsts_pkg::MODE_LINE: begin
               if (c == lsts_pkg::CHAR_NEWLINE) begin
                  mode = lsts_pkg::MODE_PLAIN;
                  return 1'b1;
               end
               return 1'b0;
            end
            lsts_pkg::MODE_OPEN, lsts_pkg::MODE_COPEN: begin
               if (c == lsts_pkg::CHAR_EQUAL) begin
                  // level saturates at the bound and flags it
                  if (open_level >= MAX_LEVEL) begin
                     open_level = 5'(MAX_LEVEL);
                     level_over = 1'b1;
                  end else begin
                     open_level++;
                  end
                  return mode == lsts_pkg::MODE_OPEN;
               end
               if (c == lsts_pkg::CHAR_LBRACKET) begin
                  mode = lsts_pkg::MODE_LONG;
                  close_count = '0;
                  return 1'b0;
               end
               // failed opener: plain text, or line comment after two dashes
               if (mode == lsts_pkg::MODE_OPEN) begin
                  mode = lsts_pkg::MODE_PLAIN;
                  plain_char(c);
                  return 1'b1;
               end
               if (c == lsts_pkg::CHAR_NEWLINE) begin
                  mode = lsts_pkg::MODE_PLAIN;
                  return 1'b1;
               end
               mode = lsts_pkg::MODE_LINE;
               return 1'b0;
            end
            lsts_pkg::MODE_QUOTE: begin
               if (c == lsts_pkg::CHAR_BACKSLASH)
                  mode = lsts_pkg::MODE_ESCAPE;
               else if (c == (dq_string ? lsts_pkg::CHAR_DQUOTE : lsts_pkg::CHAR_SQUOTE))
                  mode = lsts_pkg::MODE_PLAIN;
               return 1'b0;
            end
            lsts_pkg::MODE_ESCAPE: begin
               mode = lsts_pkg::MODE_QUOTE;
               return 1'b0;
            end
            lsts_pkg::MODE_LONG: begin
               if (c == lsts_pkg::CHAR_RBRACKET) begin
                  if (close_count != 0 && close_count - 5'd1 == open_level) begin
                     mode = lsts_pkg::MODE_PLAIN;
                     close_count = '0;
                  end else begin
                     close_count = 5'd1;
                  end
               end else if (c == lsts_pkg::CHAR_EQUAL && close_count != 0) begin
                  if (close_count - 5'd1 < open_level) close_count++;
                  else close_count = '0;
               end else begin
                  close_count = '0;
               end
               return 1'b0;
            end
            default: begin
               mode = lsts_pkg::MODE_PLAIN;
               return 1'b0;
            end
         endcase
      endfunction

      // window positions hi down to hi-len+1 spell text, oldest byte in plain code
      function bit window_holds(int hi, string text);
         if (!(win_valid[hi] && win_plain[hi])) return 1'b0;
         for (int k = 0; k < text.len(); k++) begin
            if (!win_valid[hi - k] || win_byte[hi - k] != text[k]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function bit edge_free(int pos);
         return !win_valid[pos] || !ident_char(win_byte[pos]);
      endfunction

      function void push_char(logic [7:0] c);
         bit plain;
         plain = scan_char(c);
         for (int i = lsts_pkg::WIN_DEPTH - 1; i > 0; i--) begin
            win_byte[i] = win_byte[i - 1];
            win_valid[i] = win_valid[i - 1];
            win_plain[i] = win_plain[i - 1];
         end
         win_byte[0] = c;
         win_valid[0] = 1'b1;
         win_plain[0] = plain;
         if (token_close == lsts_pkg::TOKEN_CLOSE) begin
            if (window_holds(6, "<close>")) seen_flag = 1'b1;
         end else if (window_holds(4, "goto") && edge_free(5) && !ident_char(c)) begin
            seen_flag = 1'b1;
         end
      endfunction

      // accepted request: scan the byte, owe a verdict at end of source
      function void note_request(logic [7:0] c, logic has, logic last);
         if (has) push_char(c);
         if (last) begin
            // goto right at the source end has the edge as its boundary
            if (token_close == lsts_pkg::TOKEN_GOTO && window_holds(3, "goto") &&
                edge_free(4))
               seen_flag = 1'b1;
            expected_verdicts.push_back('{found: seen_flag, level_overflow: level_over});
            clear_scan();
         end
      endfunction

      function void check_verdict(logic [7:0] data, logic user);
         verdict_type want;
         checked++;
         if (expected_verdicts.size() == 0) begin
            errors++;
            $error("verdict with no source ended: found=%0d level_overflow=%0d",
                   data[0], user);
            return;
         end
         want = expected_verdicts.pop_front();
         if (data[0] !== want.found) begin
            errors++;
            $error("found: expected %0d, actual %0d", want.found, data[0]);
         end
         if (user !== want.level_overflow) begin
            errors++;
            $error("level_overflow: expected %0d, actual %0d", want.level_overflow, user);
         end
         if (want.found) found_count++;
         if (want.level_overflow) overflow_count++;
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_wdata = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_byte
   logic       req_tuser = 1'b0;    // [0] has_char
   logic       req_tlast = 1'b0;    // is_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] found, [7:1] zero
   logic       rsp_tuser;           // [0] level_overflow

   token_verdict_board board;
   logic [7:0]     src_bytes [$];
   int             burst_left = 0;
   int             sources_sent = 0;
   int             items_sent = 0;
   int             token_writes = 0;
   stall_mode_type hold_mode = STALL_NONE;
   int             hold_left = 0;

   string word_list [12] = '{"goto", "<close>", "gotox", "_goto", "go", "to",
                             "<clos", "close>", "goto9", "xgoto", "Goto", "<<close>"};

   lua_source_token_scanner #(
      .MAX_LEVEL(MAX_LEVEL)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver stalls in stretches of its own
   always @(negedge clock) begin
      if (hold_left == 0) begin
         hold_mode = stall_mode_type'($urandom_range(0, 2));
         hold_left = $urandom_range(1, 40);
      end
      hold_left--;
      case (hold_mode)
         STALL_NONE: rsp_tready <= 1'b1;
         STALL_FULL: rsp_tready <= 1'b0;
         default:    rsp_tready <= 1'($urandom_range(0, 1));
      endcase
   end

   // monitor both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_request(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) board.check_verdict(rsp_tdata, rsp_tuser);
      end
   end

   // one request, sent in bursts with random gaps
   task automatic push_request(input logic [7:0] ch, input logic has, input logic last);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tuser <= has;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // stop sending and wait until every verdict has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic write_token(input logic value);
      drain();
      repeat (4) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      board.select_token(value);
      token_writes++;
   endtask

   function automatic void append(input string s);
      for (int k = 0; k < s.len(); k++) src_bytes.push_back(s[k]);
   endfunction

   // send src_bytes as one source, ended by its last byte or by an empty request
   task automatic send_source(input bit end_empty);
      int n;
      n = src_bytes.size();
      for (int i = 0; i < n; i++) begin
         // ignored empty request now and then
         if ($urandom_range(0, 31) == 0)
            push_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         push_request(src_bytes[i], 1'b1, !end_empty && i == n - 1);
      end
      if (end_empty || n == 0) push_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent += n + ((end_empty || n == 0) ? 1 : 0);
      sources_sent++;
      src_bytes.delete();
   endtask

   // short piece of text for inside strings, comments and brackets
   function automatic void append_body(input logic close_token);
      case ($urandom_range(0, 6))
         0: append(close_token ? "<close>" : "goto");
         1: append(word_list[$urandom_range(0, 11)]);
         2: append(" ");
         3: append("\n");
         4: src_bytes.push_back(8'($urandom_range(0, 255)));
         5: append(($urandom_range(0, 1) != 0) ? "]" : "]=");
         default: append("==");
      endcase
   endfunction

   function automatic void append_fragment(input logic close_token);
      int n;
      int k;
      int j;
      case ($urandom_range(0, 11))
         0, 11: append(close_token ? "<close>" : "goto");
         1: append(word_list[$urandom_range(0, 11)]);
         2: begin
            case ($urandom_range(0, 6))
               0: append(" ");
               1: append("\n");
               2: append("(");
               3: append(";");
               4: append(",");
               5: append("\t");
               default: append(".");
            endcase
         end
         // quoted string with escapes, sometimes unterminated
         3: begin
            j = $urandom_range(0, 1);
            append(j != 0 ? "\"" : "'");
            n = $urandom_range(0, 5);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0: begin
                     append("\\");
                     src_bytes.push_back(8'($urandom_range(0, 255)));
                  end
                  1: append(j != 0 ? "'" : "\"");
                  default: append_body(close_token);
               endcase
            end
            if ($urandom_range(0, 4) != 0) append(j != 0 ? "\"" : "'");
         end
         // line comment
         4: begin
            append("--");
            n = $urandom_range(0, 3);
            repeat (n) append_body(close_token);
            if ($urandom_range(0, 3) != 0) append("\n");
         end
         // long bracket string or comment
         5, 6: begin
            if ($urandom_range(0, 1) != 0) append("--");
            append("[");
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 3);
            repeat (k) append("=");
            if ($urandom_range(0, 5) == 0) begin
               append_body(close_token);
            end else begin
               append("[");
               n = $urandom_range(0, 3);
               repeat (n) append_body(close_token);
               j = (k > MAX_LEVEL && $urandom_range(0, 1) != 0) ? MAX_LEVEL : k;
               case ($urandom_range(0, 5))
                  0: j = j + 1;
                  1: j = -1;
                  default: ;
               endcase
               if (j >= 0) begin
                  append("]");
                  repeat (j) append("=");
                  append("]");
               end
            end
         end
         7: begin
            n = $urandom_range(1, 3);
            repeat (n) src_bytes.push_back(8'($urandom_range(0, 255)));
         end
         8: append(($urandom_range(0, 1) != 0) ? "-" : "--\n");
         // failed opener, plain or after two dashes
         9: begin
            if ($urandom_range(0, 1) != 0) append("--");
            append("[");
            n = $urandom_range(0, 2);
            repeat (n) append("=");
            append_body(close_token);
         end
         default: append_body(close_token);
      endcase
   endfunction

   initial begin
      int target;
      int phase_items;
      int n;
      board = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed sources
      write_token(lsts_pkg::TOKEN_GOTO);
      push_request(8'hA5, 1'b0, 1'b0);   // empty request that ends nothing
      append("goto");
      send_source(1'b1);                 // token at the very end, empty last request
      append("'\\");
      send_source(1'b0);                 // backslash as final byte inside a string
      src_bytes.push_back(8'hFF);
      send_source(1'b0);
      append("[=[goto]=]");
      send_source(1'b0);                 // token hidden in a level one long string
      append("\"a");
      send_source(1'b0);                 // unterminated string
      write_token(lsts_pkg::TOKEN_CLOSE);
      append("<close>");
      send_source(1'b0);

      // random sources, alternating the token selection per phase
      target = 325;
      for (int phase = 0; phase < 6; phase++) begin
         write_token((phase % 2) == 0 ? lsts_pkg::TOKEN_GOTO : lsts_pkg::TOKEN_CLOSE);
         phase_items = items_sent;
         while (items_sent - phase_items < target) begin
            if ($urandom_range(0, 7) == 0) drain();
            n = $urandom_range(1, 8);
            repeat (n) append_fragment(board.token_close);
            send_source($urandom_range(0, 4) == 0);
         end
      end

      drain();
      repeat (8) @(negedge clock);
      $display("covered %0d sources in %0d requests, %0d verdicts checked",
               sources_sent, items_sent, board.checked);
      $display("%0d found, %0d overflow, token selection written %0d times",
               board.found_count, board.overflow_count, token_writes);
      if (board.errors == 0) begin
         $display("lua_source_token_scanner_tb passed");
      end else begin
         $display("lua_source_token_scanner_tb failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("lua_source_token_scanner_tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lsts_pkg.sv
hw/rtl/lsts_lexer.sv
hw/rtl/lsts_matcher.sv
hw/rtl/lua_source_token_scanner.sv
bench/lua_source_token_scanner_tb.sv
